>>> rtl/drls_pkg.sv
// Package with shared types and constants for the detour reachable location sampler.
`timescale 1ns / 1ps
package drls_pkg;

  localparam int MAX_NODES = 256;
  localparam int TIME_BITS = 24;

  typedef struct packed {
    logic                 mode;
    logic [15:0]          origin_id;
    logic [15:0]          destination_id;
    logic [TIME_BITS-1:0] entry_time;
    logic [TIME_BITS:0]   time_budget;
  } drls_in_t;

  typedef struct packed {
    logic [8:0] location_id;
    logic       last;
  } drls_out_t;

  localparam logic [1:0] REG_NODE_COUNT   = 2'd0;
  localparam logic [1:0] REG_WANTED_COUNT = 2'd1;
  localparam logic [1:0] REG_ID_OFFSET    = 2'd2;

  localparam logic [31:0] LCG_MUL = 32'd1103515245;
  localparam logic [31:0] LCG_ADD = 32'd12345;

endpackage

>>> rtl/drls_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module drls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/detour_reachable_location_sampler_unit.sv
// Top level of the detour reachable location sampler: matrix store, scan and draw control.
// A load beat writes one entry of the travel-time matrix, so loads can follow back to back.
// A query beat reads the two matrix entries of each node through the single read port of the
// matrix memory in states S_RDA, S_RDB and S_ACC; marks live in a 1-bit memory. When more
// nodes are reachable than wanted, each draw runs a generator step, a shift-and-subtract
// remainder over the 15 bits of the draw, mark read, mark check and clear, repeated until
// enough distinct nodes are found; otherwise the marks are swept in order, with states
// S_SWEEP and S_SCHK per node. Each result beat waits in an output register; zero or invalid
// queries emit one zero beat per cycle while the output is not stalled. The next input beat
// can be taken while the final result beat of a query still waits, but configuration is
// accepted only while the block is idle and no result beat waits.
`timescale 1ns / 1ps
module detour_reachable_location_sampler_unit
  import drls_pkg::*;
#(
  parameter int MAX_CHOICES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  drls_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output drls_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int NB = $clog2(MAX_NODES);
  localparam int MB = 2 * NB;
  localparam int CB = $clog2(MAX_NODES + 1);
  localparam int WB = $clog2(MAX_CHOICES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RDA, S_RDB, S_ACC, S_PICK, S_MOD, S_MRD, S_MCHK, S_SWEEP, S_SCHK, S_EMIT
  } state_t;

  state_t            state;
  logic [8:0]        node_count;
  logic [6:0]        wanted_count;
  logic [15:0]       id_offset;
  logic [31:0]       rnd;
  drls_in_t          item;
  logic [NB-1:0]     oi, di, j;
  logic [CB-1:0]     n;
  logic [WB-1:0]     w, cnt;
  logic [CB-1:0]     reach;
  logic [TIME_BITS-1:0] ta;
  logic              zero_mode, draw_mode;
  logic [NB-1:0]     pick;
  logic [14:0]       draw;
  logic [CB-1:0]     rem;
  logic [3:0]        bitc;
  logic [8:0]        nxt_loc;
  logic              out_v;
  drls_out_t         out_r;

  logic              m_we;
  logic [MB-1:0]     m_waddr, m_raddr;
  logic [TIME_BITS-1:0] m_rdata;
  logic              k_we, k_wd, k_rd;
  logic [NB-1:0]     k_waddr, k_raddr;

  logic [16:0]       ro, rd;
  logic [CB-1:0]     n_eff;
  logic [WB-1:0]     w_eff;
  logic [TIME_BITS:0] tsum;
  logic              hit;
  logic [31:0]       rnd_next;
  logic [CB:0]       rem_step, rem_sub;
  logic [CB-1:0]     rem_new;
  logic              emit_fire;

  always_comb begin
    ro = {1'b0, in_data.origin_id} - {1'b0, id_offset};
    rd = {1'b0, in_data.destination_id} - {1'b0, id_offset};
    if (node_count == 9'd0) n_eff = CB'(1);
    else if (32'(node_count) > MAX_NODES) n_eff = CB'(MAX_NODES);
    else n_eff = CB'(node_count);
    if (wanted_count == 7'd0) w_eff = WB'(1);
    else if (32'(wanted_count) > MAX_CHOICES) w_eff = WB'(MAX_CHOICES);
    else w_eff = WB'(wanted_count);
    tsum = {1'b0, ta} + {1'b0, m_rdata};
    hit = (tsum <= item.time_budget);
    rnd_next = rnd * LCG_MUL + LCG_ADD;
    rem_step = {rem, draw[bitc]};
    rem_sub = rem_step - {1'b0, n};
    rem_new = (rem_step >= {1'b0, n}) ? rem_sub[CB-1:0] : rem_step[CB-1:0];
  end

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !out_v;
  assign out_valid = out_v;
  assign out_data  = out_r;
  assign emit_fire = (state == S_EMIT) && (!out_v || !out_stall);

  always_comb begin
    m_we = 1'b0;
    m_waddr = '0;
    m_raddr = '0;
    if (state == S_IDLE && in_valid && !in_stall && !in_data.mode && !ro[16] && !rd[16]
        && 32'(ro[15:0]) < MAX_NODES && 32'(rd[15:0]) < MAX_NODES) begin
      m_we = 1'b1;
      m_waddr = {ro[NB-1:0], rd[NB-1:0]};
    end
    if (state == S_RDA) m_raddr = {oi, j};
    else m_raddr = {j, di};
  end

  always_comb begin
    k_we = 1'b0;
    k_wd = 1'b0;
    k_waddr = j;
    k_raddr = j;
    if (state == S_ACC) begin
      k_we = 1'b1;
      k_wd = hit;
    end else if (state == S_MCHK && k_rd) begin
      k_we = 1'b1;
      k_waddr = pick;
    end
    if (state == S_MRD || state == S_MCHK) k_raddr = pick;
  end

  drls_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_NODES * MAX_NODES)) u_matrix (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(in_data.entry_time),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  drls_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_marks (
    .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wd), .raddr(k_raddr), .rdata(k_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      node_count <= 9'd256;
      wanted_count <= 7'd8;
      id_offset <= 16'd1;
      rnd <= 32'd1;
      out_v <= 1'b0;
    end else begin
      out_v <= emit_fire || (out_v && out_stall);
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_NODE_COUNT:   node_count <= cfg_data[8:0];
          REG_WANTED_COUNT: wanted_count <= cfg_data[6:0];
          REG_ID_OFFSET:    id_offset <= cfg_data[15:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall && in_data.mode) begin
            item <= in_data;
            n <= n_eff;
            w <= w_eff;
            cnt <= '0;
            reach <= '0;
            j <= '0;
            oi <= ro[NB-1:0];
            di <= rd[NB-1:0];
            zero_mode <= (in_data.origin_id == 16'd0) || (in_data.destination_id == 16'd0)
              || ro[16] || rd[16] || ro[15:0] >= 16'(n_eff) || rd[15:0] >= 16'(n_eff);
            if ((in_data.origin_id == 16'd0) || (in_data.destination_id == 16'd0)
                || ro[16] || rd[16] || ro[15:0] >= 16'(n_eff) || rd[15:0] >= 16'(n_eff))
              state <= S_EMIT;
            else state <= S_RDA;
          end
        end
        S_RDA: state <= S_RDB;
        S_RDB: begin
          ta <= m_rdata;
          state <= S_ACC;
        end
        S_ACC: begin
          if (hit) reach <= reach + CB'(1);
          if (CB'(j) + CB'(1) == n) begin
            j <= '0;
            draw_mode <= (reach + CB'(hit)) > CB'(w);
            state <= ((reach + CB'(hit)) > CB'(w)) ? S_PICK : S_SWEEP;
          end else begin
            j <= j + NB'(1);
            state <= S_RDA;
          end
        end
        S_PICK: begin
          rnd <= rnd_next;
          draw <= rnd_next[30:16];
          rem <= '0;
          bitc <= 4'd14;
          state <= S_MOD;
        end
        S_MOD: begin
          rem <= rem_new;
          if (bitc == 4'd0) begin
            pick <= NB'(rem_new);
            state <= S_MRD;
          end else bitc <= bitc - 4'd1;
        end
        S_MRD: state <= S_MCHK;
        S_MCHK: begin
          if (k_rd) begin
            nxt_loc <= 9'(pick) + 9'd1;
            state <= S_EMIT;
          end else state <= S_PICK;
        end
        S_SWEEP: state <= S_SCHK;
        S_SCHK: begin
          if (k_rd) begin
            nxt_loc <= 9'(j) + 9'd1;
            state <= S_EMIT;
          end else if (CB'(j) + CB'(1) == n) begin
            zero_mode <= 1'b1;
            state <= S_EMIT;
          end else begin
            j <= j + NB'(1);
            state <= S_SWEEP;
          end
        end
        S_EMIT: begin
          if (emit_fire) begin
            out_r.location_id <= zero_mode ? 9'd0 : nxt_loc;
            out_r.last <= (cnt + WB'(1) == w);
            cnt <= cnt + WB'(1);
            if (cnt + WB'(1) == w) state <= S_IDLE;
            else if (zero_mode) state <= S_EMIT;
            else if (draw_mode) state <= S_PICK;
            else if (CB'(j) + CB'(1) == n) begin
              zero_mode <= 1'b1;
              state <= S_EMIT;
            end else begin
              j <= j + NB'(1);
              state <= S_SWEEP;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("input accepted while busy");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (cnt < w)) else $error("result count overrun");
  a_rnd_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |=> $stable(rnd)) else $error("generator moved while idle");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_v && out_stall) |=> (out_v && $stable(out_r)))
    else $error("result beat changed while stalled");
`endif

endmodule
